// ----- hw/rtl/lor_pkg.sv -----
package lor_pkg;

   localparam int CRYSTAL_W = 17;
   localparam int LOR_W     = 33;
   localparam int VIEW_W    = 9;
   localparam int BIN_W     = 10;
   localparam int SLICE_W   = 14;

   localparam int CSR_N_W     = 11;
   localparam int CSR_R_W     = 8;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CRYSTALS_PER_RING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_COUNT        = 2'd1;

   localparam logic [CSR_N_W-1:0] CRYSTALS_PER_RING_RESET = 11'd576;
   localparam logic [CSR_R_W-1:0] RING_COUNT_RESET        = 8'd72;

   localparam int MAX_CRYSTALS_PER_RING_DEFAULT = 1024;
   localparam int MAX_RINGS_DEFAULT             = 128;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

endpackage

// ----- hw/rtl/lor_index_from_crystal_pair_unit.sv -----
// Channel  Direction  Words                                   Handshake
// req      in         crystal pair                            req_tvalid / req_tready
// rsp      out        lor, view, bin, slice; error in tuser   rsp_tvalid / rsp_tready
// csr      in         crystals per ring, ring count           csr_write, no stall
//
// One pair is taken in every cycle while the output is not stalled; each result passes
// through the input stage, the ring division and the view, shift, order and product stages.
// Reset is synchronous; it empties the pipeline and restores both registers.
// A stalled output freezes every stage, so no word is lost or repeated.
module lor_index_from_crystal_pair_unit #(
   parameter int MAX_CRYSTALS_PER_RING = lor_pkg::MAX_CRYSTALS_PER_RING_DEFAULT,
   parameter int MAX_RINGS             = lor_pkg::MAX_RINGS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // crystal_a, crystal_b, zero pad
   input  logic [lor_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // lor_index, view_index, bin_index, slice_index, zero pad
   output logic [lor_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // id_error
   output logic                                rsp_tuser,
   input  logic                                csr_write,
   input  logic [lor_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lor_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW  = lor_pkg::CRYSTAL_W;
   localparam int LOW = lor_pkg::LOR_W;
   localparam int VIW = lor_pkg::VIEW_W;
   localparam int BIW = lor_pkg::BIN_W;
   localparam int SLW = lor_pkg::SLICE_W;
   localparam int CNW = lor_pkg::CSR_N_W;
   localparam int CRW = lor_pkg::CSR_R_W;
   localparam int ODW = lor_pkg::RSP_DATA_W;

   localparam int PW  = $clog2(MAX_CRYSTALS_PER_RING);
   localparam int NW  = $clog2(MAX_CRYSTALS_PER_RING + 1);
   localparam int QW  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
   localparam int RW  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS + 1) : 1;
   localparam int DW  = CW + QW;
   localparam int NRW = NW + RW;
   localparam int NNW = 2 * NW;
   localparam int SW  = QW + RW + 1;
   localparam int VTW = PW + NW;
   localparam int VBW = VTW + 1;
   localparam int PRW = SW + NNW;
   localparam int LW  = ((PRW > VBW) ? PRW : VBW) + 1;

   typedef struct packed {
      logic          err;
      logic [CW-1:0] rem_a;
      logic [CW-1:0] rem_b;
      logic [QW-1:0] q_a;
      logic [QW-1:0] q_b;
   } div_type;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Configuration and derived constants.
   logic [CNW-1:0] csr_n_ff;
   logic [CRW-1:0] csr_r_ff;
   logic [NW-1:0]  n_eff_in, n_ff;
   logic [RW-1:0]  r_eff_in, r_ff;
   logic [NRW-1:0] nr_ff;
   logic [NNW-1:0] nn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_n_ff <= lor_pkg::CRYSTALS_PER_RING_RESET;
         csr_r_ff <= lor_pkg::RING_COUNT_RESET;
      end else if (csr_write) begin
         if (csr_index == lor_pkg::CSR_CRYSTALS_PER_RING) begin
            csr_n_ff <= csr_wdata[CNW-1:0];
         end else if (csr_index == lor_pkg::CSR_RING_COUNT) begin
            csr_r_ff <= csr_wdata[CRW-1:0];
         end
      end
   end

   always_comb begin
      if (32'(csr_n_ff) < 2) begin
         n_eff_in = NW'(2);
      end else if (32'(csr_n_ff) > MAX_CRYSTALS_PER_RING) begin
         n_eff_in = NW'(MAX_CRYSTALS_PER_RING);
      end else begin
         n_eff_in = NW'(csr_n_ff);
      end
      if (csr_r_ff == '0) begin
         r_eff_in = RW'(1);
      end else if (32'(csr_r_ff) > MAX_RINGS) begin
         r_eff_in = RW'(MAX_RINGS);
      end else begin
         r_eff_in = RW'(csr_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      n_ff  <= n_eff_in;
      r_ff  <= r_eff_in;
      nr_ff <= NRW'(n_eff_in) * NRW'(r_eff_in);
      nn_ff <= NNW'(n_eff_in - NW'(1)) * NNW'(n_eff_in >> 1);
   end

   // Input stage.
   logic          s0_valid_ff;
   logic [CW-1:0] s0_a_ff, s0_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_a_ff <= req_tdata[CW-1:0];
         s0_b_ff <= req_tdata[2*CW-1:CW];
      end
   end

   // Ring division, one quotient bit per stage, most significant first.
   div_type       div_src [QW+1];
   logic [QW:0]   div_src_valid;
   div_type       div_in  [QW];
   div_type       div_ff  [QW];
   logic [QW-1:0] div_valid_ff;

   assign div_src[0] = {(NRW'(0) + s0_a_ff >= nr_ff) || (NRW'(0) + s0_b_ff >= nr_ff),
                        s0_a_ff, s0_b_ff, QW'(0), QW'(0)};
   assign div_src_valid[0] = s0_valid_ff;

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int K = QW - 1 - j;
      logic [DW-1:0] dsub;

      assign dsub                 = DW'(n_ff) << K;
      assign div_src[j+1]         = div_ff[j];
      assign div_src_valid[j+1]   = div_valid_ff[j];

      always_comb begin
         div_in[j] = div_src[j];
         if (DW'(div_src[j].rem_a) >= dsub) begin
            div_in[j].rem_a  = div_src[j].rem_a - dsub[CW-1:0];
            div_in[j].q_a[K] = 1'b1;
         end
         if (DW'(div_src[j].rem_b) >= dsub) begin
            div_in[j].rem_b  = div_src[j].rem_b - dsub[CW-1:0];
            div_in[j].q_b[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            div_valid_ff[j] <= div_src_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   div_type dq;
   assign dq = div_src[QW];

   // View stage.
   logic          v_valid_ff, v_err_ff;
   logic [PW-1:0] v_pa_ff, v_pb_ff, v_view_ff, v_view_in;
   logic [QW-1:0] v_ra_ff, v_rb_ff;
   logic [PW:0]   v_sum;

   always_comb begin
      v_sum = PW'(dq.rem_a) + (PW+1)'(dq.rem_b[PW-1:0]);
      if (v_sum >= (PW+1)'(n_ff)) begin
         v_sum = v_sum - (PW+1)'(n_ff);
      end
      v_view_in = v_sum[PW:1];
   end

   // Shift stage.
   logic          h_valid_ff, h_err_ff;
   logic [PW-1:0] h_view_ff;
   logic [NW-1:0] h_sa_ff, h_sb_ff, h_sa_in, h_sb_in;
   logic [QW-1:0] h_ra_ff, h_rb_ff;

   always_comb begin
      if (v_pa_ff > v_view_ff) begin
         h_sa_in = NW'(v_pa_ff) - NW'(v_view_ff);
      end else begin
         h_sa_in = NW'(v_pa_ff) + n_ff - NW'(v_view_ff);
      end
      if (v_pb_ff > v_view_ff) begin
         h_sb_in = NW'(v_pb_ff) - NW'(v_view_ff);
      end else begin
         h_sb_in = NW'(v_pb_ff) + n_ff - NW'(v_view_ff);
      end
   end

   // Order stage.
   logic          c_valid_ff, c_err_ff;
   logic [PW-1:0] c_view_ff, c_bin_ff, c_bin_in;
   logic [QW-1:0] c_r1_ff, c_r2_ff, c_r1_in, c_r2_in;
   logic [NW-1:0] c_diff;

   always_comb begin
      if (h_sa_ff > h_sb_ff) begin
         c_diff  = h_sa_ff - h_sb_ff;
         c_r1_in = h_ra_ff;
         c_r2_in = h_rb_ff;
      end else begin
         c_diff  = h_sb_ff - h_sa_ff;
         c_r1_in = h_rb_ff;
         c_r2_in = h_ra_ff;
      end
      c_bin_in = PW'(n_ff - NW'(1) - c_diff);
   end

   // Product stages.
   logic           m1_valid_ff, m1_err_ff;
   logic [PW-1:0]  m1_view_ff, m1_bin_ff;
   logic [SW-1:0]  m1_slice_ff;
   logic [VTW-1:0] m1_vterm_ff;

   logic           m2_valid_ff, m2_err_ff;
   logic [PW-1:0]  m2_view_ff, m2_bin_ff;
   logic [SW-1:0]  m2_slice_ff;
   logic [PRW-1:0] m2_prod_ff;
   logic [VBW-1:0] m2_vb_ff;

   logic           m3_valid_ff, m3_err_ff;
   logic [LOW-1:0] m3_lor_ff;
   logic [VIW-1:0] m3_view_ff;
   logic [BIW-1:0] m3_bin_ff;
   logic [SLW-1:0] m3_slice_ff;
   logic [LW-1:0]  m3_sum;

   assign m3_sum = LW'(m2_prod_ff) + LW'(m2_vb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff  <= 1'b0;
         h_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (adv) begin
         v_valid_ff  <= div_src_valid[QW];
         h_valid_ff  <= v_valid_ff;
         c_valid_ff  <= h_valid_ff;
         m1_valid_ff <= c_valid_ff;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_err_ff  <= dq.err;
         v_pa_ff   <= dq.rem_a[PW-1:0];
         v_pb_ff   <= dq.rem_b[PW-1:0];
         v_ra_ff   <= dq.q_a;
         v_rb_ff   <= dq.q_b;
         v_view_ff <= v_view_in;

         h_err_ff  <= v_err_ff;
         h_view_ff <= v_view_ff;
         h_sa_ff   <= h_sa_in;
         h_sb_ff   <= h_sb_in;
         h_ra_ff   <= v_ra_ff;
         h_rb_ff   <= v_rb_ff;

         c_err_ff  <= h_err_ff;
         c_view_ff <= h_view_ff;
         c_bin_ff  <= c_bin_in;
         c_r1_ff   <= c_r1_in;
         c_r2_ff   <= c_r2_in;

         m1_err_ff   <= c_err_ff;
         m1_view_ff  <= c_view_ff;
         m1_bin_ff   <= c_bin_ff;
         m1_slice_ff <= SW'(c_r1_ff) * SW'(r_ff) + SW'(c_r2_ff);
         m1_vterm_ff <= VTW'(c_view_ff) * VTW'(n_ff - NW'(1));

         m2_err_ff   <= m1_err_ff;
         m2_view_ff  <= m1_view_ff;
         m2_bin_ff   <= m1_bin_ff;
         m2_slice_ff <= m1_slice_ff;
         m2_prod_ff  <= PRW'(m1_slice_ff) * PRW'(nn_ff);
         m2_vb_ff    <= VBW'(m1_vterm_ff) + VBW'(m1_bin_ff);

         m3_err_ff <= m2_err_ff;
         if (m2_err_ff) begin
            m3_lor_ff   <= '0;
            m3_view_ff  <= '0;
            m3_bin_ff   <= '0;
            m3_slice_ff <= '0;
         end else begin
            m3_lor_ff   <= m3_sum[LOW-1:0];
            m3_view_ff  <= VIW'(m2_view_ff);
            m3_bin_ff   <= BIW'(m2_bin_ff);
            m3_slice_ff <= SLW'(m2_slice_ff);
         end
      end
   end

   assign rsp_tvalid = m3_valid_ff;
   assign rsp_tuser  = m3_err_ff;
   assign rsp_tdata  = ODW'({m3_slice_ff, m3_bin_ff, m3_view_ff, m3_lor_ff});

endmodule
